// ===== hw/rtl/pdfm_pkg.sv =====
// Shared types, codes and constants of the PWM duty and frequency meter.
`default_nettype none

package pdfm_pkg;

  // Field widths of the stream words
  localparam int OP_W      = 2;
  localparam int TIME_W    = 48;
  localparam int DUTY_W    = 14;
  localparam int FREQ_W    = 24;
  localparam int MIN_PER_W = 16;
  localparam int COUNT_W   = 32;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;

  // Defaults of the top-level parameters
  localparam int TIME_BITS_DEF   = 48;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Measurement constants
  localparam int unsigned MIN_TOTAL_US = 1000;
  localparam int unsigned DUTY_SCALE   = 10000;
  localparam int unsigned FREQ_SCALE   = 16000000;
  localparam int          FSCALE_W     = 24;
  localparam int          PROD_W       = COUNT_W + FSCALE_W;
  localparam logic [MIN_PER_W-1:0] MIN_PER_RST = 16'd1;

  // Divider: quotient bits per run, the top one flags overflow
  localparam int QUO_BITS = 25;
  localparam int ITER_W   = $clog2(QUO_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_EDGE  = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pdfm_queue.sv =====
// Short FIFO of read jobs between the capture front and the divider back.
`default_nettype none

module pdfm_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [Width-1:0]    data_i,
  input  wire logic                pop_i,
  output logic [Width-1:0]         data_o,
  output pdfm_pkg::q_status_t      stat_o
);
  import pdfm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (fill_q == CntW'(Depth));
  assign stat_o.empty = (fill_q == '0);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("job queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== hw/rtl/pdfm_front.sv =====
// Capture front: accumulates high and low time and periods, queues read jobs.
`default_nettype none

module pdfm_front #(
  parameter int TimeBits = pdfm_pkg::TIME_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_valid_i,
  output logic                                    s_ready_o,
  input  wire logic [pdfm_pkg::OP_W-1:0]          op_i,
  input  wire logic [pdfm_pkg::TIME_W-1:0]        time_i,
  input  wire logic                               level_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [pdfm_pkg::MIN_PER_W-1:0]     cfg_wdata_i,
  input  wire pdfm_pkg::q_status_t                q_stat_i,
  output logic                                    push_o,
  // job: {ok, count, total, high}
  output logic [2*TimeBits+pdfm_pkg::COUNT_W:0]   job_o
);
  import pdfm_pkg::*;

  logic [TimeBits-1:0]  last_q, last_d;
  logic                 level_q, level_d;
  logic [TimeBits-1:0]  high_q, high_d;
  logic [TimeBits-1:0]  low_q, low_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [MIN_PER_W-1:0] min_q;

  logic                 accept;
  logic [TimeBits-1:0]  t;
  logic [TimeBits-1:0]  delta;
  logic [TimeBits-1:0]  add_base;
  logic [TimeBits:0]    add_sum;
  logic [TimeBits-1:0]  add_sat;
  logic [TimeBits:0]    tot_sum;
  logic [TimeBits-1:0]  tot_sat;
  logic [COUNT_W-1:0]   count_inc;
  logic                 job_ok;

  assign s_ready_o = !q_stat_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign t         = TimeBits'(time_i);
  assign delta     = t - last_q;
  assign add_base  = level_q ? high_q : low_q;
  assign add_sum   = {1'b0, add_base} + {1'b0, delta};
  assign add_sat   = add_sum[TimeBits] ? '1 : add_sum[TimeBits-1:0];
  assign tot_sum   = {1'b0, high_q} + {1'b0, low_q};
  assign tot_sat   = tot_sum[TimeBits] ? '1 : tot_sum[TimeBits-1:0];
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  assign job_ok    = (count_q >= COUNT_W'(min_q)) &&
                     (tot_sat >= TimeBits'(MIN_TOTAL_US));
  assign job_o     = {job_ok, count_q, tot_sat, high_q};

  always_comb begin
    last_d  = last_q;
    level_d = level_q;
    high_d  = high_q;
    low_d   = low_q;
    count_d = count_q;
    push_o  = 1'b0;
    if (accept) begin
      unique case (op_e'(op_i))
        OP_EDGE: begin
          last_d  = t;
          level_d = level_i;
          if (level_q) begin
            high_d = add_sat;
          end else begin
            low_d = add_sat;
          end
          if (level_i) begin
            count_d = count_inc;
          end
        end
        OP_START: begin
          last_d  = t;
          level_d = level_i;
        end
        OP_READ: begin
          // snapshot goes to the queue, totals start over
          push_o  = 1'b1;
          high_d  = '0;
          low_d   = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      level_q <= 1'b0;
      high_q  <= '0;
      low_q   <= '0;
      count_q <= '0;
      min_q   <= MIN_PER_RST;
    end else begin
      last_q  <= last_d;
      level_q <= level_d;
      high_q  <= high_d;
      low_q   <= low_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (count_q == '0) && (high_q == '0) && (low_q == '0))
    else $error("totals not cleared after read");

endmodule

`default_nettype wire

// ===== hw/rtl/pdfm_back.sv =====
// Divider back: works out duty and frequency of a read job, holds the result word.
`default_nettype none

module pdfm_back #(
  parameter int TimeBits = pdfm_pkg::TIME_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pdfm_pkg::q_status_t                q_stat_i,
  input  wire logic [2*TimeBits+pdfm_pkg::COUNT_W:0] job_i,
  output logic                                    pop_o,
  output logic                                    m_valid_o,
  input  wire logic                               m_ready_i,
  output logic                                    res_ok_o,
  output logic [pdfm_pkg::DUTY_W-1:0]             duty_o,
  output logic [pdfm_pkg::FREQ_W-1:0]             freq_o
);
  import pdfm_pkg::*;

  localparam int CalcW = (TimeBits + QUO_BITS > PROD_W + 1) ?
                         (TimeBits + QUO_BITS) : (PROD_W + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DUTY_LD = 3'd1;
  localparam logic [2:0] ST_DUTY    = 3'd2;
  localparam logic [2:0] ST_FREQ_LD = 3'd3;
  localparam logic [2:0] ST_FREQ    = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [TimeBits-1:0] hi_q, hi_d;
  logic [TimeBits-1:0] tot_q, tot_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [CalcW-1:0]    rem_q, rem_d;
  logic [CalcW-1:0]    div_q, div_d;
  logic [QUO_BITS-1:0] quo_q, quo_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic                ok_q, ok_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic [FREQ_W-1:0]   freq_q, freq_d;
  logic                out_valid_q, out_valid_d;
  logic                out_ok_q;
  logic [DUTY_W-1:0]   out_duty_q;
  logic [FREQ_W-1:0]   out_freq_q;
  logic                out_load;

  logic [TimeBits+DUTY_W-1:0] duty_prod;
  logic [PROD_W-1:0]          freq_prod;
  logic [CalcW-1:0]           duty_num;
  logic [CalcW-1:0]           freq_num;
  logic [CalcW-1:0]           div_init;
  logic                       ge;
  logic [QUO_BITS-1:0]        quo_step;

  assign duty_prod = (TimeBits+DUTY_W)'(hi_q) * (TimeBits+DUTY_W)'(DUTY_SCALE);
  assign freq_prod = PROD_W'(cnt_q) * PROD_W'(FREQ_SCALE);
  // add half the divisor so the quotient rounds halves up
  assign duty_num  = CalcW'(duty_prod) + CalcW'(tot_q >> 1);
  assign freq_num  = CalcW'(freq_prod) + CalcW'(tot_q >> 1);
  assign div_init  = CalcW'(tot_q) << (QUO_BITS - 1);
  assign ge        = (rem_q >= div_q);
  assign quo_step  = {quo_q[QUO_BITS-2:0], ge};

  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;

  always_comb begin
    state_d     = state_q;
    hi_d        = hi_q;
    tot_d       = tot_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    div_d       = div_q;
    quo_d       = quo_q;
    iter_d      = iter_q;
    ok_d        = ok_q;
    duty_d      = duty_q;
    freq_d      = freq_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          hi_d  = job_i[TimeBits-1:0];
          tot_d = job_i[2*TimeBits-1:TimeBits];
          cnt_d = job_i[2*TimeBits+COUNT_W-1:2*TimeBits];
          if (job_i[2*TimeBits+COUNT_W]) begin
            state_d = ST_DUTY_LD;
          end else begin
            ok_d    = 1'b0;
            duty_d  = '0;
            freq_d  = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_DUTY_LD, ST_FREQ_LD: begin
        rem_d   = (state_q == ST_DUTY_LD) ? duty_num : freq_num;
        div_d   = div_init;
        quo_d   = '0;
        iter_d  = ITER_W'(QUO_BITS - 1);
        state_d = (state_q == ST_DUTY_LD) ? ST_DUTY : ST_FREQ;
      end
      ST_DUTY, ST_FREQ: begin
        // one restoring step: subtract the shifted divisor where it fits
        if (ge) begin
          rem_d = rem_q - div_q;
        end
        div_d  = div_q >> 1;
        quo_d  = quo_step;
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) begin
          if (state_q == ST_DUTY) begin
            duty_d  = (quo_step > QUO_BITS'(DUTY_SCALE)) ?
                      DUTY_W'(DUTY_SCALE) : quo_step[DUTY_W-1:0];
            state_d = ST_FREQ_LD;
          end else begin
            freq_d  = quo_step[QUO_BITS-1] ? '1 : quo_step[FREQ_W-1:0];
            ok_d    = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    tot_q  <= tot_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    iter_q <= iter_d;
    ok_q   <= ok_d;
    duty_q <= duty_d;
    freq_q <= freq_d;
    if (out_load) begin
      out_ok_q   <= ok_q;
      out_duty_q <= duty_q;
      out_freq_q <= freq_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_ok_o  = out_ok_q;
  assign duty_o    = out_duty_q;
  assign freq_o    = out_freq_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_duty_q == '0) && (out_freq_q == '0))
    else $error("invalid result carries nonzero fields");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q <= DUTY_W'(DUTY_SCALE)))
    else $error("duty above full scale");

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_duty_frequency_meter.sv =====
// Top level of the PWM duty and frequency meter: front, job queue and divider back.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: time_us, level
//  m_axis   out  m_axis_tvalid/m_axis_tready   tuser: valid_res; tdata: duty, freq
//  cfg      in   cfg_we_i                      cfg_wdata_i: min_periods
//
//  Edge and start words are accepted back to back while the job queue is not full.
//  For a read job with its ok flag set, one shared 25-step restoring divider in the
//  back runs once for duty and once for frequency, plus load and hand-off.
//  Up to QueueDepth read jobs wait between front and back; the front stalls
//  only while that queue is full. Reset is asynchronous; min_periods resets to 1.
`default_nettype none

module pwm_duty_frequency_meter #(
  parameter int TimeBits   = pdfm_pkg::TIME_BITS_DEF,
  parameter int QueueDepth = pdfm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [47:0] time_us, [48] level, [55:49] zero
  input  wire logic [pdfm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] op
  input  wire logic [pdfm_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [13:0] duty_centi_percent, [37:14] frequency_q4, [39:38] zero
  output logic [pdfm_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // [0] valid_res
  output logic [0:0]                            m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [pdfm_pkg::MIN_PER_W-1:0]   cfg_wdata_i
);
  import pdfm_pkg::*;

  localparam int JobW = 2 * TimeBits + COUNT_W + 1;

  q_status_t         q_stat;
  logic              push;
  logic              pop;
  logic [JobW-1:0]   job_in;
  logic [JobW-1:0]   job_out;
  logic              res_ok;
  logic [DUTY_W-1:0] duty;
  logic [FREQ_W-1:0] freq;

  pdfm_front #(
    .TimeBits (TimeBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .op_i        (s_axis_tuser),
    .time_i      (s_axis_tdata[TIME_W-1:0]),
    .level_i     (s_axis_tdata[TIME_W]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (job_in)
  );

  pdfm_queue #(
    .Width (JobW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .stat_o (q_stat)
  );

  pdfm_back #(
    .TimeBits (TimeBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .job_i     (job_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_ok_o  (res_ok),
    .duty_o    (duty),
    .freq_o    (freq)
  );

  assign m_axis_tdata = {(M_TDATA_W - DUTY_W - FREQ_W)'(0), freq, duty};
  assign m_axis_tuser = res_ok;

endmodule

`default_nettype wire
